[src/jls_pkg.sv]
// Shared types, codes and fixed-point helpers for the Jacobi solver.
`timescale 1ns / 1ps
package jls_pkg;

   localparam int MAX_N   = 16;
   localparam int IDX_W   = $clog2(MAX_N);
   localparam int CADDR_W = 2 * IDX_W;
   localparam int Q_W     = 48;
   localparam int Q_DEPTH = 4;
   localparam int QPTR_W  = $clog2(Q_DEPTH);

   // element kinds on the request tuser
   localparam logic [1:0] KIND_COEFF = 2'd0;
   localparam logic [1:0] KIND_RHS   = 2'd1;
   localparam logic [1:0] KIND_GUESS = 2'd2;

   // store targets after decode
   localparam logic [1:0] OP_NONE  = 2'd0;
   localparam logic [1:0] OP_COEFF = 2'd1;
   localparam logic [1:0] OP_RHS   = 2'd2;
   localparam logic [1:0] OP_GUESS = 2'd3;

   // result status
   localparam logic [1:0] ST_CONVERGED = 2'd0;
   localparam logic [1:0] ST_LIMIT     = 2'd1;
   localparam logic [1:0] ST_ZERO_DIAG = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_SIZE  = 2'd0;
   localparam logic [1:0] CSR_TOL   = 2'd1;
   localparam logic [1:0] CSR_LIMIT = 2'd2;

   localparam logic [4:0]  SIZE_RST  = 5'd16;
   localparam logic [31:0] TOL_RST   = 32'd4;
   localparam logic [19:0] LIMIT_RST = 20'd1000000;

   localparam logic [Q_W-1:0] Q_MAX = 48'h7FFF_FFFF_FFFF;
   localparam logic [Q_W-1:0] Q_MIN = 48'h8000_0000_0000;

   typedef struct packed {
      logic [1:0]         op;
      logic [CADDR_W-1:0] addr;
      logic [Q_W-1:0]     value;
      logic               last;
   } cmd_type;

   typedef struct packed {
      logic [4:0]  size;
      logic [31:0] tol;
      logic [19:0] limit;
   } cfg_type;

   function automatic logic [Q_W-1:0] mag_f(input logic [Q_W-1:0] v);
      mag_f = v[Q_W-1] ? (~v + 48'd1) : v;
   endfunction

   // apply sign to a magnitude and saturate to Q16.32
   function automatic logic [Q_W-1:0] sat_result_f(input logic [50:0] m, input logic neg);
      logic [Q_W-1:0] r;
      if (neg) begin
         r = (m >= 51'h0_8000_0000_0000) ? Q_MIN : (~m[Q_W-1:0] + 48'd1);
      end else begin
         r = (m > 51'h0_7FFF_FFFF_FFFF) ? Q_MAX : m[Q_W-1:0];
      end
      sat_result_f = r;
   endfunction

endpackage

[src/jls_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module jls_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

[src/jls_front.sv]
// Request decode and command queue feeding the solver core.
`timescale 1ns / 1ps
module jls_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [55:0]      req_tdata,   // row_index[3:0], col_index[7:4], element_value[55:8]
   input  logic [1:0]       req_tuser,   // req_type[1:0]
   input  logic             req_tlast,
   input  logic             pop,
   output logic             cmd_valid,
   output jls_pkg::cmd_type cmd
);
   import jls_pkg::*;

   cmd_type           q_ff [Q_DEPTH];
   cmd_type           q_in;
   logic [QPTR_W-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [QPTR_W:0]   cnt_ff, cnt_in;
   logic [IDX_W-1:0]  row, col;
   logic              push;

   assign row        = req_tdata[IDX_W-1:0];
   assign col        = req_tdata[2*IDX_W-1:IDX_W];
   assign req_tready = (cnt_ff != Q_DEPTH[QPTR_W:0]);
   assign push       = req_tvalid && req_tready;
   assign cmd_valid  = (cnt_ff != '0);
   assign cmd        = q_ff[rp_ff];

   always_comb begin
      q_in.value = req_tdata[55:8];
      q_in.last  = req_tlast;
      q_in.addr  = {{IDX_W{1'b0}}, row};
      unique case (req_tuser)
         KIND_COEFF: begin
            q_in.op   = OP_COEFF;
            q_in.addr = {row, col};
         end
         KIND_RHS:   q_in.op = OP_RHS;
         KIND_GUESS: q_in.op = OP_GUESS;
         default:    q_in.op = OP_NONE;
      endcase
   end

   always_comb begin
      wp_in  = push ? wp_ff + 1'b1 : wp_ff;
      rp_in  = pop ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + {{QPTR_W{1'b0}}, push} - {{QPTR_W{1'b0}}, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wp_ff] <= q_in;
      end
   end

endmodule

[src/jls_back.sv]
// Solver core: store writes, diagonal check, Jacobi sweeps and result emit.
`timescale 1ns / 1ps
module jls_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  jls_pkg::cmd_type cmd,
   output logic             pop,
   input  jls_pkg::cfg_type cfg,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [55:0]      rsp_tdata,   // result_index[3:0], result_value[51:4], zero[55:52]
   output logic [1:0]       rsp_tuser,   // solve_status[1:0]
   output logic             rsp_tlast
);
   import jls_pkg::*;

   localparam logic [4:0] S_IDLE    = 5'd0;
   localparam logic [4:0] S_DRD     = 5'd1;
   localparam logic [4:0] S_DCHK    = 5'd2;
   localparam logic [4:0] S_ERR     = 5'd3;
   localparam logic [4:0] S_RHS_RD  = 5'd4;
   localparam logic [4:0] S_RHS_LD  = 5'd5;
   localparam logic [4:0] S_ROW_RD  = 5'd6;
   localparam logic [4:0] S_ROW_LD  = 5'd7;
   localparam logic [4:0] S_MUL     = 5'd8;
   localparam logic [4:0] S_ACC     = 5'd9;
   localparam logic [4:0] S_DIAG_RD = 5'd10;
   localparam logic [4:0] S_DIV_LD  = 5'd11;
   localparam logic [4:0] S_DIV     = 5'd12;
   localparam logic [4:0] S_DIV_WR  = 5'd13;
   localparam logic [4:0] S_UPD_RD  = 5'd14;
   localparam logic [4:0] S_UPD     = 5'd15;
   localparam logic [4:0] S_END     = 5'd16;
   localparam logic [4:0] S_OUT_RD  = 5'd17;
   localparam logic [4:0] S_OUT     = 5'd18;

   logic [4:0]       state_ff, state_in;
   logic [IDX_W-1:0] i_ff, i_in, j_ff, j_in, nm1_ff, nm1_in;
   logic [19:0]      limit_ff, limit_in, sweep_ff, sweep_in;
   logic [31:0]      tol_ff, tol_in;
   logic [Q_W-1:0]   acc_ff, acc_in, amag_ff, amag_in, bmag_ff, bmag_in;
   logic             neg_ff, neg_in, ovf_ff, ovf_in;
   logic [2:0]       mcnt_ff, mcnt_in;
   logic [63:0]      pp_ff, pp_in;
   logic [50:0]      sum_ff, sum_in;
   logic [79:0]      div_ff, div_in;
   logic [48:0]      rem_ff, rem_in;
   logic [Q_W-1:0]   dmag_ff, dmag_in;
   logic [6:0]       dcnt_ff, dcnt_in;
   logic             dzero_ff, dzero_in, dsat_ff, dsat_in;
   logic [Q_W-1:0]   max_ff, max_in;
   logic [1:0]       status_ff, status_in;

   logic             rvalid_ff, rvalid_in, rlast_ff, rlast_in;
   logic [IDX_W-1:0] ridx_ff, ridx_in;
   logic [Q_W-1:0]   rval_ff, rval_in;
   logic [1:0]       rstat_ff, rstat_in;

   logic               c_we, r_we, s_we, n_we;
   logic [CADDR_W-1:0] c_waddr, c_raddr;
   logic [IDX_W-1:0]   r_waddr, s_waddr, s_raddr, n_waddr;
   logic [Q_W-1:0]     c_wdata, r_wdata, s_wdata, n_wdata;
   logic [Q_W-1:0]     c_rdata, r_rdata, s_rdata, n_rdata;

   logic             slot_free;
   logic [31:0]      opa, opb;
   logic [Q_W-1:0]   prod, qval, ut, ud, chg;
   logic [48:0]      dif, shifted, adif;
   logic [19:0]      sweep_nx;
   logic [4:0]       nsz;

   jls_ram #(.WIDTH(Q_W), .DEPTH(MAX_N * MAX_N)) u_coeff (
      .clock(clock), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
      .raddr(c_raddr), .rdata(c_rdata));
   jls_ram #(.WIDTH(Q_W), .DEPTH(MAX_N)) u_rhs (
      .clock(clock), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
      .raddr(i_ff), .rdata(r_rdata));
   jls_ram #(.WIDTH(Q_W), .DEPTH(MAX_N)) u_sol (
      .clock(clock), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
      .raddr(s_raddr), .rdata(s_rdata));
   jls_ram #(.WIDTH(Q_W), .DEPTH(MAX_N)) u_next (
      .clock(clock), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
      .raddr(i_ff), .rdata(n_rdata));

   assign slot_free  = !rvalid_ff || rsp_tready;
   assign pop        = cmd_valid && (state_ff == S_IDLE);
   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = {4'b0, rval_ff, ridx_ff};
   assign rsp_tuser  = rstat_ff;
   assign rsp_tlast  = rlast_ff;

   // store ports
   always_comb begin
      c_we    = pop && (cmd.op == OP_COEFF);
      c_waddr = cmd.addr;
      c_wdata = cmd.value;
      r_we    = pop && (cmd.op == OP_RHS);
      r_waddr = cmd.addr[IDX_W-1:0];
      r_wdata = cmd.value;
      n_we    = (state_ff == S_DIV_WR);
      n_waddr = i_ff;
      n_wdata = qval;
      c_raddr = (state_ff == S_ROW_RD) ? {i_ff, j_ff} : {i_ff, i_ff};
      s_raddr = (state_ff == S_ROW_RD) ? j_ff : i_ff;
      if (state_ff == S_UPD) begin
         s_we    = 1'b1;
         s_waddr = i_ff;
         s_wdata = n_rdata;
      end else begin
         s_we    = pop && (cmd.op == OP_GUESS);
         s_waddr = cmd.addr[IDX_W-1:0];
         s_wdata = cmd.value;
      end
   end

   // shared datapath pieces
   always_comb begin
      opa      = mcnt_ff[1] ? amag_ff[31:0] : {16'b0, amag_ff[47:32]};
      opb      = mcnt_ff[0] ? bmag_ff[31:0] : {16'b0, bmag_ff[47:32]};
      prod     = ovf_ff ? (neg_ff ? Q_MIN : Q_MAX) : sat_result_f(sum_ff, neg_ff);
      dif      = {acc_ff[Q_W-1], acc_ff} - {prod[Q_W-1], prod};
      shifted  = {rem_ff[47:0], div_ff[79]};
      qval     = dzero_ff ? '0 :
                 dsat_ff  ? (neg_ff ? Q_MIN : Q_MAX) : sat_result_f(div_ff[50:0], neg_ff);
      ut       = mag_f(acc_ff);
      ud       = mag_f(c_rdata);
      adif     = {n_rdata[Q_W-1], n_rdata} - {s_rdata[Q_W-1], s_rdata};
      adif     = adif[48] ? (~adif + 49'd1) : adif;
      chg      = adif[48] ? {Q_W{1'b1}} : adif[Q_W-1:0];
      sweep_nx = sweep_ff + 20'd1;
      nsz      = (cfg.size == 5'd0) ? 5'd1 :
                 (cfg.size > MAX_N[4:0]) ? MAX_N[4:0] : cfg.size;
   end

   always_comb begin
      state_in  = state_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      nm1_in    = nm1_ff;
      limit_in  = limit_ff;
      tol_in    = tol_ff;
      sweep_in  = sweep_ff;
      acc_in    = acc_ff;
      amag_in   = amag_ff;
      bmag_in   = bmag_ff;
      neg_in    = neg_ff;
      ovf_in    = ovf_ff;
      mcnt_in   = mcnt_ff;
      pp_in     = pp_ff;
      sum_in    = sum_ff;
      div_in    = div_ff;
      rem_in    = rem_ff;
      dmag_in   = dmag_ff;
      dcnt_in   = dcnt_ff;
      dzero_in  = dzero_ff;
      dsat_in   = dsat_ff;
      max_in    = max_ff;
      status_in = status_ff;
      rvalid_in = rvalid_ff && !rsp_tready;
      ridx_in   = ridx_ff;
      rval_in   = rval_ff;
      rstat_in  = rstat_ff;
      rlast_in  = rlast_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (pop && cmd.last) begin
               nm1_in   = 4'(nsz - 5'd1);
               limit_in = (cfg.limit == 20'd0) ? 20'd1 : cfg.limit;
               tol_in   = cfg.tol;
               i_in     = '0;
               state_in = S_DRD;
            end
         end
         S_DRD: state_in = S_DCHK;
         S_DCHK: begin
            if (c_rdata == '0) begin
               state_in = S_ERR;
            end else if (i_ff == nm1_ff) begin
               i_in     = '0;
               sweep_in = '0;
               state_in = S_RHS_RD;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = S_DRD;
            end
         end
         S_ERR: begin
            if (slot_free) begin
               rvalid_in = 1'b1;
               ridx_in   = '0;
               rval_in   = '0;
               rstat_in  = ST_ZERO_DIAG;
               rlast_in  = 1'b1;
               state_in  = S_IDLE;
            end
         end
         S_RHS_RD: state_in = S_RHS_LD;
         S_RHS_LD: begin
            acc_in   = r_rdata;
            j_in     = '0;
            state_in = S_ROW_RD;
         end
         S_ROW_RD: begin
            // skip the diagonal term
            if (j_ff == i_ff) begin
               if (j_ff == nm1_ff) begin
                  state_in = S_DIAG_RD;
               end else begin
                  j_in = j_ff + 1'b1;
               end
            end else begin
               state_in = S_ROW_LD;
            end
         end
         S_ROW_LD: begin
            amag_in  = mag_f(c_rdata);
            bmag_in  = mag_f(s_rdata);
            neg_in   = c_rdata[Q_W-1] ^ s_rdata[Q_W-1];
            sum_in   = '0;
            ovf_in   = 1'b0;
            mcnt_in  = '0;
            state_in = S_MUL;
         end
         S_MUL: begin
            // four partial products; each is summed the cycle after it is formed
            if (mcnt_ff != 3'd4) begin
               pp_in = opa * opb;
            end
            if (mcnt_ff != 3'd0) begin
               unique case (2'(mcnt_ff - 3'd1))
                  2'd0: begin
                     ovf_in = (pp_ff[63:16] != '0);
                     sum_in = sum_ff + {3'b0, pp_ff[15:0], 32'b0};
                  end
                  2'd1, 2'd2: sum_in = sum_ff + {3'b0, pp_ff[47:0]};
                  default:    sum_in = sum_ff + {19'b0, pp_ff[63:32]};
               endcase
            end
            mcnt_in = mcnt_ff + 3'd1;
            if (mcnt_ff == 3'd4) begin
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            acc_in = (dif[48] != dif[47]) ? (dif[48] ? Q_MIN : Q_MAX) : dif[Q_W-1:0];
            if (j_ff == nm1_ff) begin
               state_in = S_DIAG_RD;
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = S_ROW_RD;
            end
         end
         S_DIAG_RD: state_in = S_DIV_LD;
         S_DIV_LD: begin
            neg_in   = acc_ff[Q_W-1] ^ c_rdata[Q_W-1];
            dmag_in  = ud;
            dzero_in = (ud == '0);
            dsat_in  = ({15'b0, ut} >= {ud, 15'b0});
            div_in   = {ut, 32'b0};
            rem_in   = '0;
            dcnt_in  = '0;
            state_in = ((ud == '0) || ({15'b0, ut} >= {ud, 15'b0})) ? S_DIV_WR : S_DIV;
         end
         S_DIV: begin
            if (shifted >= {1'b0, dmag_ff}) begin
               rem_in = shifted - {1'b0, dmag_ff};
               div_in = {div_ff[78:0], 1'b1};
            end else begin
               rem_in = shifted;
               div_in = {div_ff[78:0], 1'b0};
            end
            dcnt_in = dcnt_ff + 7'd1;
            if (dcnt_ff == 7'd79) begin
               state_in = S_DIV_WR;
            end
         end
         S_DIV_WR: begin
            if (i_ff == nm1_ff) begin
               i_in     = '0;
               max_in   = '0;
               state_in = S_UPD_RD;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = S_RHS_RD;
            end
         end
         S_UPD_RD: state_in = S_UPD;
         S_UPD: begin
            if (chg > max_ff) begin
               max_in = chg;
            end
            if (i_ff == nm1_ff) begin
               state_in = S_END;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = S_UPD_RD;
            end
         end
         S_END: begin
            sweep_in = sweep_nx;
            i_in     = '0;
            if ((max_ff > {16'b0, tol_ff}) && (sweep_nx < limit_ff)) begin
               state_in = S_RHS_RD;
            end else begin
               status_in = (max_ff > {16'b0, tol_ff}) ? ST_LIMIT : ST_CONVERGED;
               state_in  = S_OUT_RD;
            end
         end
         S_OUT_RD: state_in = S_OUT;
         S_OUT: begin
            if (slot_free) begin
               rvalid_in = 1'b1;
               ridx_in   = i_ff;
               rval_in   = s_rdata;
               rstat_in  = status_ff;
               rlast_in  = (i_ff == nm1_ff);
               if (i_ff == nm1_ff) begin
                  state_in = S_IDLE;
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = S_OUT_RD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         rvalid_ff <= 1'b0;
         sweep_ff  <= '0;
         max_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         rvalid_ff <= rvalid_in;
         sweep_ff  <= sweep_in;
         max_ff    <= max_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff      <= i_in;
      j_ff      <= j_in;
      nm1_ff    <= nm1_in;
      limit_ff  <= limit_in;
      tol_ff    <= tol_in;
      acc_ff    <= acc_in;
      amag_ff   <= amag_in;
      bmag_ff   <= bmag_in;
      neg_ff    <= neg_in;
      ovf_ff    <= ovf_in;
      mcnt_ff   <= mcnt_in;
      pp_ff     <= pp_in;
      sum_ff    <= sum_in;
      div_ff    <= div_in;
      rem_ff    <= rem_in;
      dmag_ff   <= dmag_in;
      dcnt_ff   <= dcnt_in;
      dzero_ff  <= dzero_in;
      dsat_ff   <= dsat_in;
      status_ff <= status_in;
      ridx_ff   <= ridx_in;
      rval_ff   <= rval_in;
      rstat_ff  <= rstat_in;
      rlast_ff  <= rlast_in;
   end

   a_mul_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MUL |-> mcnt_ff <= 3'd4)
      else $error("multiply step counter out of range");

   a_err_single: assert property (@(posedge clock) disable iff (reset)
      rvalid_ff && rstat_ff == ST_ZERO_DIAG |-> rlast_ff && ridx_ff == '0 && rval_ff == '0)
      else $error("zero diagonal result is not a single closing beat");

   a_sweep_limit: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_END |-> sweep_ff < limit_ff)
      else $error("sweep count passed the limit");

   a_quot_fits: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV_WR && !dzero_ff && !dsat_ff |-> div_ff[79:47] == '0)
      else $error("quotient wider than expected");

endmodule

[src/jacobi_linear_solver.sv]
// Top level of the Jacobi solver: register port, decode queue and solver core.
//
// Usage: stream matrix entries, right-hand side and initial guess on req_*,
// one beat each, kind on req_tuser. A beat with req_tlast starts a solve over
// the first matrix_size unknowns. The result channel rsp_* then carries one beat
// per unknown (index, value, status), tlast on the final one; a zero diagonal
// gives a single beat with status 2 instead.
// Loading accepts one element per cycle while the four-entry decode queue has room.
// A solve first checks every diagonal entry, then runs sweeps: per row, the right-hand
// side load, the shared 32x32 multiplier loop over the off-diagonal terms and the
// bit-serial divider (skipped when the quotient saturates), then an update pass over
// all unknowns; the sweep count is set by the tolerance and the iteration limit.
// Emit reads each result from the solution store before it is sent.
// Reset (synchronous) empties the queue, idles the core and restores the
// registers; store contents are unknown until loaded. A stalled rsp_tready
// holds the result register and the core waits; the queue keeps taking beats while it has room.
// The user must write the registers only while the block is idle; the block does not enforce it.
`timescale 1ns / 1ps
module jacobi_linear_solver (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // row_index[3:0], col_index[7:4], element_value[55:8]
   input  logic [1:0]  req_tuser,   // req_type[1:0]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // result_index[3:0], result_value[51:4], zero[55:52]
   output logic [1:0]  rsp_tuser,   // solve_status[1:0]
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import jls_pkg::*;

   cfg_type cfg_ff, cfg_in;
   cmd_type cmd;
   logic    cmd_valid, pop, wr;

   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (csr_paddr[3:2])
            CSR_SIZE:  cfg_in.size  = csr_pwdata[4:0];
            CSR_TOL:   cfg_in.tol   = csr_pwdata;
            CSR_LIMIT: cfg_in.limit = csr_pwdata[19:0];
            default:   cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         CSR_SIZE:  csr_prdata = {27'b0, cfg_ff.size};
         CSR_TOL:   csr_prdata = cfg_ff.tol;
         CSR_LIMIT: csr_prdata = {12'b0, cfg_ff.limit};
         default:   csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.size  <= SIZE_RST;
         cfg_ff.tol   <= TOL_RST;
         cfg_ff.limit <= LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   jls_front u_front (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .pop(pop), .cmd_valid(cmd_valid), .cmd(cmd));

   jls_back u_back (
      .clock(clock), .reset(reset),
      .cmd_valid(cmd_valid), .cmd(cmd), .pop(pop), .cfg(cfg_ff),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast));

endmodule
